>>> src/shs_pkg.sv
// shared types, constants and helper functions for the sha-256 stream hash core
`default_nettype none
package shs_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  // what the block being compressed holds
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD_LEN,
    BLK_PAD_ONLY,
    BLK_LEN_ONLY
  } blk_kind_t;

  typedef struct packed {
    blk_kind_t   kind;
    logic [5:0]  fill;
    logic [23:0] acc;
    logic [63:0] bit_len;
  } msg_ctl_t;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LENGTH_POS  = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_TAB [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> src/sha256_stream_hash_core.sv
// sha-256 over a byte stream: input gathering, block ram, round sequencer and digest output
`default_nettype none
// Takes one message byte per input word and returns the eight SHA-256 digest
// words, h0 first, after a word with end_of_message set; word_last marks h7.
// A byte that does not complete a 64-byte block is taken without a stall. A
// byte that completes a block stalls the input: ST_INIT loads the working
// variables, 64 rounds of the single round unit run at one round per cycle,
// and ST_FINAL folds the result into the chain value. End of message adds
// one such pass (two when 56 or more bytes of the last block are held), then
// the eight digest words are offered one per cycle while the output is not
// stalled. No input is taken while a block is compressed or the digest drains.
// Message bytes sit in a 16 x 32-bit ram; padding and length words are
// generated on the fly, so no clearing pass is needed after reset.
module sha256_stream_hash_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire shs_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output shs_pkg::out_word_t     out_data
);
  import shs_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  blk_kind_t   kind_r;
  blk_kind_t   pad_kind;
  logic [5:0]  fill_r;
  logic [5:0]  fill_after;
  logic [60:0] len_r;
  logic [23:0] acc_r;
  logic        eom_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  word_t       chain_r [HASH_WORDS];
  word_t       vars_r  [HASH_WORDS];
  word_t       vars_nxt [HASH_WORDS];

  logic        in_acc;
  logic        byte_take;
  logic        blk_full;
  logic        start_cmp;
  logic        ram_we;
  logic [3:0]  ram_raddr;
  word_t       ram_word;
  word_t       sched;
  msg_ctl_t    msg_ctl;

  assign in_acc     = in_valid && !in_stall;
  assign byte_take  = in_acc && in_data.has_byte;
  assign blk_full   = byte_take && (fill_r == 6'(BLOCK_BYTES - 1));
  assign start_cmp  = in_acc && (blk_full || in_data.end_of_message);
  assign fill_after = byte_take ? fill_r + 6'd1 : fill_r;
  // no room for the length after the pad byte: an extra block follows
  assign pad_kind   = (fill_after >= 6'(LENGTH_POS)) ? BLK_PAD_ONLY : BLK_PAD_LEN;

  // a full word goes to the ram with its fourth byte
  assign ram_we    = byte_take && (fill_r[1:0] == 2'd3);
  assign ram_raddr = (state_r == ST_INIT) ? 4'd0 : rnd_r[3:0] + 4'd1;

  shs_ram #(
    .WIDTH (32),
    .DEPTH (BLOCK_WORDS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[5:2]),
    .wdata ({acc_r, in_data.data_byte}),
    .raddr (ram_raddr),
    .rdata (ram_word)
  );

  assign msg_ctl.kind    = kind_r;
  assign msg_ctl.fill    = fill_r;
  assign msg_ctl.acc     = acc_r;
  assign msg_ctl.bit_len = {len_r, 3'b000};

  shs_msg u_msg (
    .clk        (clk),
    .idx        (rnd_r[3:0]),
    .from_block (rnd_r[5:4] == 2'd0),
    .shift_en   (state_r == ST_ROUND),
    .ram_word   (ram_word),
    .ctl        (msg_ctl),
    .sched      (sched)
  );

  shs_round u_round (
    .v_in  (vars_r),
    .k     (K_TAB[rnd_r]),
    .w     (sched),
    .v_out (vars_nxt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_cmp) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (kind_r == BLK_DATA && !eom_r) begin
          state_nxt = ST_IDLE;
        end else if (kind_r == BLK_PAD_LEN || kind_r == BLK_LEN_ONLY) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_INIT;
        end
      end
      ST_OUT: begin
        if (!out_stall && oidx_r == 3'(HASH_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall             = (state_r != ST_IDLE);
    out_valid            = (state_r == ST_OUT);
    out_data.digest_word = chain_r[oidx_r];
    out_data.word_last   = (oidx_r == 3'(HASH_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= BLK_DATA;
      fill_r  <= '0;
      len_r   <= '0;
      eom_r   <= 1'b0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      for (int j = 0; j < HASH_WORDS; j++) begin
        chain_r[j] <= IV_TAB[j];
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (byte_take) begin
            acc_r  <= {acc_r[15:0], in_data.data_byte};
            fill_r <= fill_r + 6'd1;
            len_r  <= len_r + 61'd1;
          end
          if (start_cmp) begin
            eom_r  <= in_data.end_of_message;
            kind_r <= blk_full ? BLK_DATA : pad_kind;
          end
        end
        ST_INIT: begin
          rnd_r <= '0;
          for (int j = 0; j < HASH_WORDS; j++) begin
            vars_r[j] <= chain_r[j];
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          for (int j = 0; j < HASH_WORDS; j++) begin
            vars_r[j] <= vars_nxt[j];
          end
        end
        ST_FINAL: begin
          for (int j = 0; j < HASH_WORDS; j++) begin
            chain_r[j] <= chain_r[j] + vars_r[j];
          end
          // a full data block with the end pending: padding starts a fresh block
          if (kind_r == BLK_DATA && eom_r) begin
            kind_r <= BLK_PAD_LEN;
          end else if (kind_r == BLK_PAD_ONLY) begin
            kind_r <= BLK_LEN_ONLY;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'(HASH_WORDS - 1)) begin
              fill_r <= '0;
              len_r  <= '0;
              eom_r  <= 1'b0;
              for (int j = 0; j < HASH_WORDS; j++) begin
                chain_r[j] <= IV_TAB[j];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/shs_ram.sv
// generic single write port ram with registered read
`default_nettype none
module shs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/shs_msg.sv
// message word selection with padding and the rolling 16-word schedule window
`default_nettype none
module shs_msg (
  input  wire logic              clk,
  input  wire logic [3:0]        idx,
  input  wire logic              from_block,
  input  wire logic              shift_en,
  input  wire shs_pkg::word_t    ram_word,
  input  wire shs_pkg::msg_ctl_t ctl,
  output shs_pkg::word_t         sched
);
  import shs_pkg::*;

  word_t      w_r [BLOCK_WORDS];
  word_t      blk_word;
  word_t      part_word;
  word_t      expand;
  logic [3:0] full_words;

  assign full_words = ctl.fill[5:2];

  // last partial word with the pad byte placed after the held bytes
  always_comb begin
    case (ctl.fill[1:0])
      2'd0:    part_word = {PAD_BYTE, 24'h0};
      2'd1:    part_word = {ctl.acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    part_word = {ctl.acc[15:0], PAD_BYTE, 8'h0};
      2'd3:    part_word = {ctl.acc[23:0], PAD_BYTE};
      default: part_word = '0;
    endcase
  end

  always_comb begin
    case (ctl.kind)
      BLK_DATA: begin
        blk_word = ram_word;
      end
      BLK_PAD_LEN, BLK_PAD_ONLY: begin
        if (idx < full_words) begin
          blk_word = ram_word;
        end else if (idx == full_words) begin
          blk_word = part_word;
        end else begin
          blk_word = '0;
        end
        if (ctl.kind == BLK_PAD_LEN && idx == 4'd14) begin
          blk_word = ctl.bit_len[63:32];
        end else if (ctl.kind == BLK_PAD_LEN && idx == 4'd15) begin
          blk_word = ctl.bit_len[31:0];
        end
      end
      BLK_LEN_ONLY: begin
        if (idx == 4'd14) begin
          blk_word = ctl.bit_len[63:32];
        end else if (idx == 4'd15) begin
          blk_word = ctl.bit_len[31:0];
        end else begin
          blk_word = '0;
        end
      end
      default: blk_word = '0;
    endcase
  end

  // w_r[15] is the newest word, w_r[0] the one sixteen rounds back
  assign expand = w_r[0] + small_sig0(w_r[1]) + w_r[9] + small_sig1(w_r[14]);
  assign sched  = from_block ? blk_word : expand;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[BLOCK_WORDS - 1] <= sched;
    end
  end

endmodule
`default_nettype wire

>>> src/shs_round.sv
// one sha-256 compression round over the eight working variables
`default_nettype none
module shs_round (
  input  wire shs_pkg::word_t v_in  [8],
  input  wire shs_pkg::word_t k,
  input  wire shs_pkg::word_t w,
  output shs_pkg::word_t      v_out [8]
);
  import shs_pkg::*;

  word_t ch;
  word_t maj;
  word_t t_one;
  word_t t_two;

  always_comb begin
    ch    = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    maj   = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t_one = v_in[7] + big_sig1(v_in[4]) + ch + k + w;
    t_two = big_sig0(v_in[0]) + maj;
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t_one;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t_one + t_two;
  end

endmodule
`default_nettype wire

>>> bench/sha256_stream_hash_core_test.sv
// self-checking bench for the sha-256 stream hash core with its own digest predictor
`default_nettype none
module sha256_stream_hash_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shs_pkg::in_word_t;
  import shs_pkg::out_word_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 470;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // predictor state
  logic [31:0] hash_chain [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [60:0] msg_len;

  in_word_t  pending_words [$];
  out_word_t digest_expect [$];
  int        stim_total = 0;
  int        words_taken = 0;
  int        sender_idle;
  int        receiver_idle;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  sha256_stream_hash_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_chain[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_chain[j] = hash_chain[j] + v[j];
  endfunction

  function automatic void start_message();
    for (int j = 0; j < 8; j++) hash_chain[j] = START_HASH[j];
    block_fill = 0;
    msg_len = '0;
  endfunction

  // advance the predictor by one accepted word, queue the digest on end of message
  function automatic void absorb_word(in_word_t w);
    logic [63:0] bit_len;
    out_word_t res;
    if (w.has_byte) begin
      msg_block[block_fill] = w.data_byte;
      msg_len = msg_len + 61'd1;
      block_fill++;
      if (block_fill == 64) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (!w.end_of_message) return;
    msg_block[block_fill] = 8'h80;
    for (int j = block_fill + 1; j < 64; j++) msg_block[j] = 8'h00;
    // no room for the length: pad block goes out alone
    if (block_fill + 1 > 56) begin
      compress_msg_block();
      for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
    end
    bit_len = {msg_len, 3'b000};
    for (int j = 0; j < 8; j++) msg_block[56 + j] = bit_len[63 - 8*j -: 8];
    compress_msg_block();
    for (int j = 0; j < 8; j++) begin
      res.digest_word = hash_chain[j];
      res.word_last = (j == 7);
      digest_expect = {digest_expect, res};
    end
    start_message();
  endfunction

  function automatic void add_word(logic [7:0] b, logic has, logic eom);
    in_word_t w;
    w.data_byte = b;
    w.has_byte = has;
    w.end_of_message = eom;
    pending_words = {pending_words, w};
  endfunction

  // idle rates by phase of the run
  always_comb begin
    if (words_taken < stim_total / 3) begin
      sender_idle = 33;
      receiver_idle = 54;
    end else if (words_taken < 2 * stim_total / 3) begin
      sender_idle = 54;
      receiver_idle = 33;
    end else begin
      sender_idle = 0;
      receiver_idle = 0;
    end
  end

  always @(posedge clk) begin : drive_proc
    logic took;
    int nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      nxt = words_taken;
      if (took) begin
        absorb_word(in_data);
        nxt = words_taken + 1;
        words_taken <= nxt;
      end
      if (!in_valid || took) begin
        if (nxt < stim_total && $urandom_range(99) >= sender_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_words[nxt];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest word %h", out_data.digest_word);
          mismatch_count++;
        end else begin
          want = digest_expect.pop_front();
          if (out_data.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, out_data.digest_word);
            mismatch_count++;
          end
          if (out_data.word_last !== want.word_last) begin
            $error("word_last: expected %b, got %b", want.word_last, out_data.word_last);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stim_proc
    int counted;
    int msg_bytes;
    int pick;
    logic split_end;
    start_message();
    for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;

    // directed part
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hff, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'ha5, 1'b0, 1'b1);
    add_word(8'h61, 1'b1, 1'b0);
    add_word(8'h62, 1'b1, 1'b0);
    add_word(8'h63, 1'b1, 1'b1);
    add_word(8'h12, 1'b1, 1'b0);
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'h34, 1'b1, 1'b1);
    add_word(8'h5a, 1'b0, 1'b1);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'hff, 1'b1, 1'b1);

    // random messages, lengths biased toward block and padding boundaries
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      pick = $urandom_range(9);
      case (pick)
        6: msg_bytes = $urandom_range(55, 57);
        7: msg_bytes = $urandom_range(63, 65);
        8: msg_bytes = $urandom_range(119, 129);
        9: msg_bytes = $urandom_range(13, 54);
        default: msg_bytes = $urandom_range(12);
      endcase
      split_end = (msg_bytes == 0) || $urandom_range(1);
      for (int k = 0; k < msg_bytes; k++) begin
        if ($urandom_range(99) < 6) add_word(8'($urandom_range(255)), 1'b0, 1'b0);
        add_word(8'($urandom_range(255)), 1'b1, !split_end && (k == msg_bytes - 1));
        counted++;
      end
      if (split_end) begin
        add_word(8'($urandom_range(255)), 1'b0, 1'b1);
        counted++;
      end
    end
    stim_total = pending_words.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < stim_total || digest_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/shs_pkg.sv
src/shs_ram.sv
src/shs_msg.sv
src/shs_round.sv
src/sha256_stream_hash_core.sv
bench/sha256_stream_hash_core_test.sv
